// ===== hdl/ihex_pkg.sv =====
`default_nettype none
package ihex_pkg;

   localparam int CapacityWidth = 21;
   localparam int AddressWidth  = 21;
   localparam int SegmentWidth  = 20;
   localparam int QueueDepthDefault = 2;
   localparam logic [CapacityWidth-1:0] CapacityReset = 21'd65536;

   localparam logic [7:0] CharColon   = 8'h3A;
   localparam logic [7:0] CharNewline = 8'h0A;
   localparam logic [7:0] CharZero    = 8'h30;
   localparam logic [7:0] CharNine    = 8'h39;
   localparam logic [7:0] CharUpperA  = 8'h41;
   localparam logic [7:0] CharUpperF  = 8'h46;

   localparam logic [7:0] RecData    = 8'h00;
   localparam logic [7:0] RecEof     = 8'h01;
   localparam logic [7:0] RecSegment = 8'h02;

   typedef enum logic [1:0] {
      KIND_WRITE = 2'd0,
      KIND_DONE  = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ERR_NO_COLON    = 3'd0,
      ERR_BAD_HEX     = 3'd1,
      ERR_CAPACITY    = 3'd2,
      ERR_UNSUPPORTED = 3'd3,
      ERR_CHECKSUM    = 3'd4,
      ERR_NO_END      = 3'd5
   } error_type;

   // classified character, handed from the front to the back
   typedef struct packed {
      logic       end_of_input;
      logic       colon;
      logic       newline;
      logic       hex;
      logic [3:0] digit;
   } token_type;

   typedef struct packed {
      kind_type                 kind;
      logic [AddressWidth-1:0]  address;
      logic [7:0]               data_byte;
      error_type                error_code;
      logic [CapacityWidth-1:0] image_size;
   } result_type;

endpackage
`default_nettype wire

// ===== hdl/ihex_classify.sv =====
`default_nettype none
module ihex_classify (
   input  wire logic [7:0]        character,
   input  wire logic              end_of_input,
   output ihex_pkg::token_type    token
);

   logic       is_dec;
   logic       is_alpha;
   logic [7:0] dec_off;
   logic [7:0] alpha_off;

   always_comb begin
      is_dec    = (character >= ihex_pkg::CharZero) && (character <= ihex_pkg::CharNine);
      is_alpha  = (character >= ihex_pkg::CharUpperA) && (character <= ihex_pkg::CharUpperF);
      dec_off   = character - ihex_pkg::CharZero;
      alpha_off = character - ihex_pkg::CharUpperA + 8'd10;
      token.end_of_input = end_of_input;
      token.colon        = (character == ihex_pkg::CharColon);
      token.newline      = (character == ihex_pkg::CharNewline);
      token.hex          = is_dec || is_alpha;
      if (is_dec) begin
         token.digit = dec_off[3:0];
      end else begin
         token.digit = alpha_off[3:0];
      end
   end

endmodule
`default_nettype wire

// ===== hdl/ihex_queue.sv =====
`default_nettype none
module ihex_queue #(
   parameter int DEPTH = ihex_pkg::QueueDepthDefault  // two or more
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire ihex_pkg::token_type push_token,
   output logic                     full,
   input  wire logic                pop,
   output logic                     not_empty,
   output ihex_pkg::token_type      head_token
);

   localparam int PtrWidth   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CountWidth = $clog2(DEPTH + 1);
   localparam logic [PtrWidth-1:0]   LastPtr   = PtrWidth'(DEPTH - 1);
   localparam logic [CountWidth-1:0] FullCount = CountWidth'(DEPTH);

   ihex_pkg::token_type slots_ff [DEPTH];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic                  do_push;
   logic                  do_pop;

   always_comb begin
      full       = (count_ff == FullCount);
      not_empty  = (count_ff != '0);
      head_token = slots_ff[rd_ptr_ff];
      do_push    = push && !full;
      do_pop     = pop && not_empty;
      wr_ptr_in  = wr_ptr_ff;
      rd_ptr_in  = rd_ptr_ff;
      count_in   = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_token;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/ihex_engine.sv =====
`default_nettype none
module ihex_engine (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_we,
   input  wire logic [ihex_pkg::CapacityWidth-1:0]    csr_wdata,
   input  wire logic                                  token_valid,
   input  wire ihex_pkg::token_type                   token,
   output logic                                       token_pop,
   output logic                                       result_valid,
   input  wire logic                                  result_ready,
   output ihex_pkg::result_type                       result
);

   typedef enum logic [3:0] {
      PH_COLON, PH_LEN, PH_ADDR_HI, PH_ADDR_LO, PH_TYPE,
      PH_DATA, PH_SEG_HI, PH_SEG_LO, PH_CHECK, PH_TAIL
   } phase_type;

   typedef enum logic [1:0] {
      ST_RUNNING, ST_DONE, ST_ERROR
   } status_type;

   localparam int AW = ihex_pkg::AddressWidth;
   localparam int CW = ihex_pkg::CapacityWidth;

   phase_type            phase_ff, phase_in;
   status_type           status_ff, status_in;
   logic [3:0]           high_ff, high_in;
   logic                 half_ff, half_in;
   logic [7:0]           length_ff, length_in;
   logic [15:0]          raddr_ff, raddr_in;
   logic [AW-1:0]        base_ff, base_in;
   logic [7:0]           done_ff, done_in;
   logic [7:0]           cksum_ff, cksum_in;
   logic [ihex_pkg::SegmentWidth-1:0] seg_ff, seg_in;
   logic [CW-1:0]        size_ff, size_in;
   logic [CW-1:0]        cap_ff, cap_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   ihex_pkg::result_type rsp_ff, rsp_in;

   logic                 fire;
   ihex_pkg::result_type res;
   logic [7:0]           byte_val;
   logic [7:0]           cksum_new;
   logic [7:0]           done_next;
   logic [CW-1:0]        extent;
   logic [CW-1:0]        new_size;

   always_comb begin
      phase_in     = phase_ff;
      status_in    = status_ff;
      high_in      = high_ff;
      half_in      = half_ff;
      length_in    = length_ff;
      raddr_in     = raddr_ff;
      base_in      = base_ff;
      done_in      = done_ff;
      cksum_in     = cksum_ff;
      seg_in       = seg_ff;
      size_in      = size_ff;
      cap_in       = csr_we ? csr_wdata : cap_ff;
      fire         = 1'b0;
      res          = '0;
      byte_val     = {high_ff, token.digit};
      cksum_new    = cksum_ff + byte_val;
      done_next    = done_ff + 8'd1;
      extent       = base_ff + {13'd0, length_ff};
      new_size     = (extent >= size_ff) ? extent : size_ff;
      token_pop    = token_valid && (!rsp_valid_ff || result_ready);

      if (token_pop && status_ff == ST_RUNNING) begin
         if (token.end_of_input) begin
            fire           = 1'b1;
            res.kind       = ihex_pkg::KIND_ERROR;
            res.error_code = (phase_ff == PH_COLON || phase_ff == PH_TAIL) ?
                             ihex_pkg::ERR_NO_END : ihex_pkg::ERR_BAD_HEX;
         end else if (phase_ff == PH_COLON) begin
            if (!token.colon) begin
               fire           = 1'b1;
               res.kind       = ihex_pkg::KIND_ERROR;
               res.error_code = ihex_pkg::ERR_NO_COLON;
            end else begin
               phase_in = PH_LEN;
               half_in  = 1'b0;
               high_in  = 4'd0;
               cksum_in = 8'd0;
            end
         end else if (phase_ff == PH_TAIL) begin
            if (token.newline) begin
               phase_in = PH_COLON;
            end
         end else if (!token.hex) begin
            fire           = 1'b1;
            res.kind       = ihex_pkg::KIND_ERROR;
            res.error_code = ihex_pkg::ERR_BAD_HEX;
         end else if (!half_ff) begin
            high_in = token.digit;
            half_in = 1'b1;
         end else begin
            half_in  = 1'b0;
            cksum_in = cksum_new;
            case (phase_ff)
               PH_LEN: begin
                  length_in = byte_val;
                  phase_in  = PH_ADDR_HI;
               end
               PH_ADDR_HI: begin
                  raddr_in = {byte_val, 8'd0};
                  phase_in = PH_ADDR_LO;
               end
               PH_ADDR_LO: begin
                  raddr_in = {raddr_ff[15:8], byte_val};
                  // base address of the record, reused by the size check and the writes
                  base_in  = {1'b0, seg_ff} + {5'd0, raddr_ff[15:8], byte_val};
                  phase_in = PH_TYPE;
               end
               PH_TYPE: begin
                  size_in = new_size;
                  done_in = 8'd0;
                  if (new_size > cap_ff) begin
                     fire           = 1'b1;
                     res.kind       = ihex_pkg::KIND_ERROR;
                     res.error_code = ihex_pkg::ERR_CAPACITY;
                  end else if (byte_val == ihex_pkg::RecData) begin
                     phase_in = (length_ff == 8'd0) ? PH_CHECK : PH_DATA;
                  end else if (byte_val == ihex_pkg::RecEof) begin
                     fire           = 1'b1;
                     res.kind       = ihex_pkg::KIND_DONE;
                     res.image_size = new_size;
                  end else if (byte_val == ihex_pkg::RecSegment && length_ff == 8'd2) begin
                     phase_in = PH_SEG_HI;
                  end else begin
                     fire           = 1'b1;
                     res.kind       = ihex_pkg::KIND_ERROR;
                     res.error_code = ihex_pkg::ERR_UNSUPPORTED;
                  end
               end
               PH_DATA: begin
                  done_in       = done_next;
                  fire          = 1'b1;
                  res.kind      = ihex_pkg::KIND_WRITE;
                  res.address   = base_ff + {13'd0, done_ff};
                  res.data_byte = byte_val;
                  if (done_next >= length_ff) begin
                     phase_in = PH_CHECK;
                  end
               end
               PH_SEG_HI: begin
                  raddr_in = {byte_val, 8'd0};
                  phase_in = PH_SEG_LO;
               end
               PH_SEG_LO: begin
                  seg_in   = {raddr_ff[15:8], byte_val, 4'd0};
                  phase_in = PH_CHECK;
               end
               default: begin
                  // checksum byte
                  if (cksum_new != 8'd0) begin
                     fire           = 1'b1;
                     res.kind       = ihex_pkg::KIND_ERROR;
                     res.error_code = ihex_pkg::ERR_CHECKSUM;
                  end else begin
                     phase_in = PH_TAIL;
                  end
               end
            endcase
         end
      end

      if (fire) begin
         status_in = (res.kind == ihex_pkg::KIND_DONE) ? ST_DONE :
                     (res.kind == ihex_pkg::KIND_ERROR) ? ST_ERROR : status_ff;
      end

      rsp_in = fire ? res : rsp_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (result_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end

      result_valid = rsp_valid_ff;
      result       = rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_COLON;
         status_ff    <= ST_RUNNING;
         high_ff      <= 4'd0;
         half_ff      <= 1'b0;
         length_ff    <= 8'd0;
         raddr_ff     <= 16'd0;
         base_ff      <= '0;
         done_ff      <= 8'd0;
         cksum_ff     <= 8'd0;
         seg_ff       <= '0;
         size_ff      <= '0;
         cap_ff       <= ihex_pkg::CapacityReset;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         status_ff    <= status_in;
         high_ff      <= high_in;
         half_ff      <= half_in;
         length_ff    <= length_in;
         raddr_ff     <= raddr_in;
         base_ff      <= base_in;
         done_ff      <= done_in;
         cksum_ff     <= cksum_in;
         seg_ff       <= seg_in;
         size_ff      <= size_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   a_status_sticky: assert property (@(posedge clock) disable iff (reset)
      status_ff != ST_RUNNING |=> status_ff == $past(status_ff))
      else $error("run status left its final value");

   a_final_item_stops: assert property (@(posedge clock) disable iff (reset)
      fire && res.kind != ihex_pkg::KIND_WRITE |=> status_ff != ST_RUNNING)
      else $error("done or error item without stopping the run");

   a_half_in_hex_phase: assert property (@(posedge clock) disable iff (reset)
      half_ff |-> phase_ff != PH_COLON && phase_ff != PH_TAIL)
      else $error("pending nibble outside a hex field");

   a_data_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DATA |-> done_ff < length_ff)
      else $error("payload count reached record length in data phase");

endmodule
`default_nettype wire

// ===== hdl/intel_hex_record_loader.sv =====
`default_nettype none
// Intel HEX record loader: takes the hex text one character per item on req_ and gives
// memory writes, a done item with the image size, or a single sticky error item on rsp_.
// A character classifier feeds a QUEUE_DEPTH-entry token queue that the record engine
// drains at one token per cycle unless a result waits on rsp_tready; the engine's state
// update is one small add and compare per character, so the block sustains one item
// per cycle when rsp_tready does not stall it. Results are registered, and req_tready
// drops only when the queue fills behind a stalled rsp_tready. csr_wdata sets the image
// capacity (reset 65536); the user must write it while the block is idle (unchecked).
module intel_hex_record_loader #(
   parameter int QUEUE_DEPTH = ihex_pkg::QueueDepthDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [20:0] csr_wdata,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // character
   input  wire logic        req_tlast,   // end_of_input
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [55:0]      rsp_tdata,   // address, data_byte, error_code, image_size
   output logic [1:0]       rsp_tuser    // kind
);

   ihex_pkg::token_type  in_token;
   ihex_pkg::token_type  head_token;
   ihex_pkg::result_type result;
   logic                 queue_full;
   logic                 queue_not_empty;
   logic                 token_pop;

   ihex_classify u_classify (
      .character    (req_tdata),
      .end_of_input (req_tlast),
      .token        (in_token)
   );

   ihex_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_tvalid),
      .push_token (in_token),
      .full       (queue_full),
      .pop        (token_pop),
      .not_empty  (queue_not_empty),
      .head_token (head_token)
   );

   ihex_engine u_engine (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_wdata    (csr_wdata),
      .token_valid  (queue_not_empty),
      .token        (head_token),
      .token_pop    (token_pop),
      .result_valid (rsp_tvalid),
      .result_ready (rsp_tready),
      .result       (result)
   );

   always_comb begin
      req_tready = !queue_full;
      rsp_tdata  = {3'd0, result.image_size, result.error_code,
                    result.data_byte, result.address};
      rsp_tuser  = result.kind;
   end

endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
`default_nettype none
module testbench;

   localparam logic [ihex_pkg::CapacityWidth-1:0] CapacityMin = '0;
   localparam logic [ihex_pkg::CapacityWidth-1:0] CapacityMax = 21'd1114095;
   localparam int IdlePercent      = 9;
   localparam int HoldCycles       = 80;
   localparam int HoldAfterResults = 150;
   localparam int SettleCycles     = 8;

   typedef enum logic [3:0] {
      SCAN_COLON, SCAN_LENGTH, SCAN_ADDR_HI, SCAN_ADDR_LO, SCAN_TYPE,
      SCAN_DATA, SCAN_SEG_HI, SCAN_SEG_LO, SCAN_CHECK, SCAN_TAIL
   } scan_phase_type;

   typedef enum logic [1:0] {LOAD_RUNNING, LOAD_DONE, LOAD_FAILED} load_state_type;

   typedef enum int {
      END_DONE, END_EOI_BETWEEN, END_EOI_INSIDE, END_NO_COLON, END_BAD_HEX,
      END_CHECKSUM, END_UNSUPPORTED, END_CAPACITY, END_EOI_AFTER_CHECK
   } ending_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } text_item_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        csr_we     = 1'b0;
   logic [20:0] csr_wdata  = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   intel_hex_record_loader u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // loader state as the predictor sees it
   scan_phase_type                         scan         = SCAN_COLON;
   load_state_type                         load_state   = LOAD_RUNNING;
   logic [3:0]                             pend_nibble  = '0;
   logic                                   nibble_odd   = 1'b0;
   logic [7:0]                             rec_length   = '0;
   logic [15:0]                            rec_address  = '0;
   logic [7:0]                             rec_bytes    = '0;
   logic [7:0]                             line_check   = '0;
   logic [ihex_pkg::SegmentWidth-1:0]      seg_base     = '0;
   logic [ihex_pkg::CapacityWidth-1:0]     image_extent = '0;
   logic [ihex_pkg::CapacityWidth-1:0]     capacity     = ihex_pkg::CapacityReset;

   ihex_pkg::result_type due_outputs[$];
   text_item_type        text_queue[$];

   // text generator bookkeeping
   logic [ihex_pkg::SegmentWidth-1:0]  gen_base     = '0;
   logic [ihex_pkg::CapacityWidth-1:0] gen_capacity = ihex_pkg::CapacityReset;
   logic [7:0]                         line_sum;
   logic [7:0]                         line_payload[$];
   int                                 chars_queued = 0;

   int  cycle_count    = 0;
   int  items_accepted = 0;
   int  results_seen   = 0;
   int  writes_checked = 0;
   int  ends_checked   = 0;
   int  mismatch_count = 0;
   int  hold_left      = 0;
   bit  held_once      = 1'b0;
   bit  req_fire       = 1'b0;
   ending_type ending;

   wire quiet = cycle_count >= 1500 && cycle_count < 2500;

   function automatic bit is_upper_hex(input logic [7:0] c);
      return (c >= ihex_pkg::CharZero && c <= ihex_pkg::CharNine) ||
             (c >= ihex_pkg::CharUpperA && c <= ihex_pkg::CharUpperF);
   endfunction

   function automatic void post(input ihex_pkg::kind_type k, input logic [20:0] a,
                                input logic [7:0] d, input ihex_pkg::error_type e,
                                input logic [20:0] s);
      ihex_pkg::result_type r;
      r.kind       = k;
      r.address    = a;
      r.data_byte  = d;
      r.error_code = e;
      r.image_size = s;
      due_outputs.push_back(r);
   endfunction

   function automatic void post_error(input ihex_pkg::error_type e);
      load_state = LOAD_FAILED;
      post(ihex_pkg::KIND_ERROR, '0, '0, e, '0);
   endfunction

   function automatic void absorb_byte(input logic [7:0] b);
      logic [20:0] extent;
      logic [20:0] write_addr;
      line_check = line_check + b;
      case (scan)
         SCAN_LENGTH: begin
            rec_length = b;
            scan = SCAN_ADDR_HI;
         end
         SCAN_ADDR_HI: begin
            rec_address = {b, 8'h00};
            scan = SCAN_ADDR_LO;
         end
         SCAN_ADDR_LO: begin
            rec_address[7:0] = b;
            scan = SCAN_TYPE;
         end
         SCAN_TYPE: begin
            // size grows before the type is looked at, end records included
            extent = {5'b0, rec_address} + {1'b0, seg_base} + {13'b0, rec_length};
            if (extent >= image_extent) image_extent = extent;
            if (image_extent > capacity) begin
               post_error(ihex_pkg::ERR_CAPACITY);
            end else begin
               rec_bytes = '0;
               if (b == ihex_pkg::RecData) begin
                  scan = (rec_length == 8'd0) ? SCAN_CHECK : SCAN_DATA;
               end else if (b == ihex_pkg::RecEof) begin
                  load_state = LOAD_DONE;
                  post(ihex_pkg::KIND_DONE, '0, '0, ihex_pkg::ERR_NO_COLON, image_extent);
               end else if (b == ihex_pkg::RecSegment && rec_length == 8'd2) begin
                  scan = SCAN_SEG_HI;
               end else begin
                  post_error(ihex_pkg::ERR_UNSUPPORTED);
               end
            end
         end
         SCAN_DATA: begin
            write_addr = {1'b0, seg_base} + {5'b0, rec_address} + {13'b0, rec_bytes};
            rec_bytes = rec_bytes + 8'd1;
            if (rec_bytes >= rec_length) scan = SCAN_CHECK;
            post(ihex_pkg::KIND_WRITE, write_addr, b, ihex_pkg::ERR_NO_COLON, '0);
         end
         SCAN_SEG_HI: begin
            rec_address = {b, 8'h00};
            scan = SCAN_SEG_LO;
         end
         SCAN_SEG_LO: begin
            seg_base = {rec_address[15:8], b, 4'h0};
            scan = SCAN_CHECK;
         end
         default: begin
            if (line_check != 8'd0) post_error(ihex_pkg::ERR_CHECKSUM);
            else scan = SCAN_TAIL;
         end
      endcase
   endfunction

   function automatic void parse_character(input logic [7:0] ch, input logic eoi);
      logic [7:0] offset;
      if (load_state != LOAD_RUNNING) return;
      if (eoi) begin
         if (scan == SCAN_COLON || scan == SCAN_TAIL) post_error(ihex_pkg::ERR_NO_END);
         else post_error(ihex_pkg::ERR_BAD_HEX);
         return;
      end
      if (scan == SCAN_COLON) begin
         if (ch != ihex_pkg::CharColon) begin
            post_error(ihex_pkg::ERR_NO_COLON);
         end else begin
            scan        = SCAN_LENGTH;
            nibble_odd  = 1'b0;
            pend_nibble = '0;
            line_check  = '0;
         end
         return;
      end
      if (scan == SCAN_TAIL) begin
         if (ch == ihex_pkg::CharNewline) scan = SCAN_COLON;
         return;
      end
      if (!is_upper_hex(ch)) begin
         post_error(ihex_pkg::ERR_BAD_HEX);
         return;
      end
      offset = (ch <= ihex_pkg::CharNine) ? ch - ihex_pkg::CharZero :
                                            ch - ihex_pkg::CharUpperA + 8'd10;
      if (!nibble_odd) begin
         pend_nibble = offset[3:0];
         nibble_odd  = 1'b1;
         return;
      end
      nibble_odd = 1'b0;
      absorb_byte({pend_nibble, offset[3:0]});
   endfunction

   // accepted items feed the predictor, accepted results are checked
   always @(posedge clock) begin : monitor
      ihex_pkg::result_type want;
      ihex_pkg::result_type got;
      cycle_count++;
      req_fire = 1'b0;
      if (csr_we) capacity = csr_wdata;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            parse_character(req_tdata, req_tlast);
            items_accepted++;
            req_fire = 1'b1;
         end
         if (rsp_tvalid && rsp_tready) begin
            got.kind       = ihex_pkg::kind_type'(rsp_tuser);
            got.address    = rsp_tdata[20:0];
            got.data_byte  = rsp_tdata[28:21];
            got.error_code = ihex_pkg::error_type'(rsp_tdata[31:29]);
            got.image_size = rsp_tdata[52:32];
            results_seen++;
            if (due_outputs.size() == 0) begin
               $error("unexpected item: kind %0d address %0h", got.kind, got.address);
               mismatch_count++;
            end else begin
               want = due_outputs.pop_front();
               if (want.kind == ihex_pkg::KIND_WRITE) writes_checked++;
               else ends_checked++;
               if (got.kind !== want.kind) begin
                  $error("kind: expected %0d, got %0d", want.kind, got.kind);
                  mismatch_count++;
               end
               if (got.address !== want.address) begin
                  $error("address: expected %0h, got %0h", want.address, got.address);
                  mismatch_count++;
               end
               if (got.data_byte !== want.data_byte) begin
                  $error("data_byte: expected %0h, got %0h", want.data_byte, got.data_byte);
                  mismatch_count++;
               end
               if (got.error_code !== want.error_code) begin
                  $error("error_code: expected %0d, got %0d", want.error_code, got.error_code);
                  mismatch_count++;
               end
               if (got.image_size !== want.image_size) begin
                  $error("image_size: expected %0h, got %0h", want.image_size, got.image_size);
                  mismatch_count++;
               end
            end
         end
      end
   end

   always @(negedge clock) begin : feeder
      text_item_type next_item;
      if (!reset && (!req_tvalid || req_fire)) begin
         if (text_queue.size() != 0 && (quiet || $urandom_range(0, 99) >= IdlePercent)) begin
            next_item = text_queue.pop_front();
            req_tdata  <= next_item.ch;
            req_tlast  <= next_item.last;
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // one long hold-off lets the block fill up behind the output
   always @(negedge clock) begin : drain_side
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (!held_once && results_seen >= HoldAfterResults) begin
         held_once = 1'b1;
         hold_left = HoldCycles - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= quiet || $urandom_range(0, 99) >= IdlePercent;
      end
   end

   function automatic logic [7:0] hex_char(input logic [3:0] n);
      logic [7:0] wide;
      wide = {4'h0, n};
      return (n < 4'd10) ? ihex_pkg::CharZero + wide : ihex_pkg::CharUpperA + wide - 8'd10;
   endfunction

   function automatic logic [7:0] noise_char();
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255)); while (c == ihex_pkg::CharNewline);
      return c;
   endfunction

   function automatic int tail_length();
      return ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 4)) : 0;
   endfunction

   task automatic push_char(input logic [7:0] c, input logic last);
      text_queue.push_back({c, last});
      chars_queued++;
   endtask

   task automatic push_hex_byte(input logic [7:0] b);
      line_sum = line_sum + b;
      push_char(hex_char(b[7:4]), 1'b0);
      push_char(hex_char(b[3:0]), 1'b0);
   endtask

   task automatic fill_payload(input int n);
      line_payload.delete();
      repeat (n) line_payload.push_back(8'($urandom_range(0, 255)));
   endtask

   // one line from line_payload; a negative tail leaves the line open
   task automatic emit_record(input logic [15:0] addr, input logic [7:0] rtype,
                              input bit corrupt, input int tail_len, input bit clamp);
      logic [15:0] at;
      logic [7:0]  check;
      int          n;
      int          room;
      at = addr;
      n  = line_payload.size();
      if (clamp && int'(gen_base) + int'(at) + n > int'(gen_capacity)) begin
         room = int'(gen_capacity) - int'(gen_base) - n;
         if (room < 0) room = 0;
         at = (room > 32'hFFFF) ? 16'hFFFF : room[15:0];
      end
      line_sum = '0;
      push_char(ihex_pkg::CharColon, 1'b0);
      push_hex_byte(n[7:0]);
      push_hex_byte(at[15:8]);
      push_hex_byte(at[7:0]);
      push_hex_byte(rtype);
      foreach (line_payload[i]) push_hex_byte(line_payload[i]);
      check = 8'd0 - line_sum;
      if (corrupt) check = check + 8'($urandom_range(1, 255));
      push_hex_byte(check);
      repeat (tail_len) push_char(noise_char(), 1'b0);
      if (tail_len >= 0) push_char(ihex_pkg::CharNewline, 1'b0);
      if (rtype == ihex_pkg::RecSegment && n == 2 && !corrupt)
         gen_base = {line_payload[0], line_payload[1], 4'h0};
   endtask

   task automatic random_records(input int char_budget, input bit with_segments);
      int stop_at;
      int pick;
      stop_at = chars_queued + char_budget;
      while (chars_queued < stop_at) begin
         pick = $urandom_range(0, 99);
         if (with_segments && pick < 15) begin
            fill_payload(2);
            emit_record(16'($urandom), ihex_pkg::RecSegment, 1'b0, tail_length(), 1'b1);
         end else begin
            fill_payload((pick < 95) ? $urandom_range(0, 16) : $urandom_range(17, 255));
            emit_record(16'($urandom), ihex_pkg::RecData, 1'b0, tail_length(), 1'b1);
         end
      end
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (text_queue.size() != 0 || req_tvalid || due_outputs.size() != 0);
      repeat (SettleCycles) @(negedge clock);
   endtask

   task automatic set_capacity(input logic [ihex_pkg::CapacityWidth-1:0] value);
      wait_idle();
      csr_wdata <= value;
      csr_we    <= 1'b1;
      @(negedge clock);
      csr_we <= 1'b0;
      gen_capacity = value;
   endtask

   initial begin : stimulus
      int          k;
      int          len;
      logic [7:0]  c;
      logic [7:0]  rtype;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // nothing may grow the image: only empty records at address zero
      set_capacity(CapacityMin);
      line_payload.delete();
      emit_record(16'h0000, ihex_pkg::RecData, 1'b0, 0, 1'b0);
      emit_record(16'h0000, ihex_pkg::RecData, 1'b0, 3, 1'b0);

      set_capacity(ihex_pkg::CapacityReset);
      line_payload = '{8'hFF};
      emit_record(16'hFFFF, ihex_pkg::RecData, 1'b0, 0, 1'b0);
      line_payload = '{8'h00, 8'hFF, 8'hA5, 8'h5A};
      emit_record(16'h0000, ihex_pkg::RecData, 1'b0, 2, 1'b0);
      fill_payload(16);
      emit_record(16'h1234, ihex_pkg::RecData, 1'b0, 1, 1'b0);
      random_records(300, 1'b0);

      set_capacity(CapacityMax);
      line_payload = '{8'hFF, 8'hFF};
      emit_record(16'h0000, ihex_pkg::RecSegment, 1'b0, 0, 1'b1);
      // top of the address space, extent lands exactly on the capacity
      fill_payload(16);
      emit_record(16'hFFEF, ihex_pkg::RecData, 1'b0, 0, 1'b0);
      line_payload = '{8'h00, 8'h00};
      emit_record(16'hFFFF, ihex_pkg::RecSegment, 1'b0, 1, 1'b1);
      fill_payload(255);
      emit_record(16'h0000, ihex_pkg::RecData, 1'b0, 0, 1'b1);
      line_payload = '{8'h12, 8'h34};
      emit_record(16'($urandom), ihex_pkg::RecSegment, 1'b0, 0, 1'b1);
      random_records(1300, 1'b1);

      // the first end or error is final, so exactly one is picked per run
      ending = ending_type'($urandom_range(0, int'(END_EOI_AFTER_CHECK)));
      case (ending)
         END_DONE: begin
            fill_payload($urandom_range(0, 4));
            emit_record(16'($urandom), ihex_pkg::RecEof, 1'($urandom_range(0, 1)),
                        tail_length(), 1'b1);
         end
         END_EOI_BETWEEN: begin
            push_char(8'($urandom_range(0, 255)), 1'b1);
         end
         END_EOI_INSIDE: begin
            push_char(ihex_pkg::CharColon, 1'b0);
            repeat ($urandom_range(0, 9)) push_char(hex_char(4'($urandom)), 1'b0);
            push_char(8'($urandom_range(0, 255)), 1'b1);
         end
         END_NO_COLON: begin
            do c = 8'($urandom_range(0, 255)); while (c == ihex_pkg::CharColon);
            push_char(($urandom_range(0, 3) == 0) ? ihex_pkg::CharNewline : c, 1'b0);
         end
         END_BAD_HEX: begin
            push_char(ihex_pkg::CharColon, 1'b0);
            repeat ($urandom_range(0, 7)) push_char(hex_char(4'($urandom)), 1'b0);
            k = $urandom_range(0, 2);
            if (k == 0) begin
               c = ihex_pkg::CharNewline;
            end else if (k == 1) begin
               c = 8'h61 + 8'($urandom_range(0, 5));
            end else begin
               do c = 8'($urandom_range(0, 255)); while (is_upper_hex(c));
            end
            push_char(c, 1'b0);
         end
         END_CHECKSUM: begin
            fill_payload($urandom_range(1, 8));
            emit_record(16'($urandom), ihex_pkg::RecData, 1'b1, 0, 1'b1);
         end
         END_UNSUPPORTED: begin
            if ($urandom_range(0, 1) == 0) begin
               rtype = 8'($urandom_range(int'(ihex_pkg::RecSegment) + 1, 255));
               len   = $urandom_range(0, 4);
            end else begin
               rtype = ihex_pkg::RecSegment;
               len   = $urandom_range(0, 3);
               if (len >= 2) len++;
            end
            fill_payload(len);
            emit_record(16'($urandom), rtype, 1'b0, 0, 1'b1);
         end
         END_CAPACITY: begin
            line_payload = '{8'hFF, 8'hFF};
            emit_record(16'h0000, ihex_pkg::RecSegment, 1'b0, 0, 1'b1);
            fill_payload($urandom_range(1, 16));
            emit_record(16'hFFFF,
                        ($urandom_range(0, 1) == 0) ? ihex_pkg::RecData : ihex_pkg::RecEof,
                        1'b0, 0, 1'b0);
         end
         default: begin
            fill_payload($urandom_range(0, 8));
            emit_record(16'($urandom), ihex_pkg::RecData, 1'b0, -1, 1'b1);
            repeat ($urandom_range(0, 3)) push_char(noise_char(), 1'b0);
            push_char(8'($urandom_range(0, 255)), 1'b1);
         end
      endcase
      // everything after the end must be ignored
      repeat (8) push_char(8'($urandom_range(0, 255)), 1'b0);
      push_char(ihex_pkg::CharColon, 1'b1);

      wait_idle();
      repeat (12) @(negedge clock);
      $display("sent %0d characters; checked %0d memory writes and %0d end items",
               items_accepted, writes_checked, ends_checked);
      $display("capacities 0, %0d and %0d; run closed by %s",
               ihex_pkg::CapacityReset, CapacityMax, ending.name());
      if (mismatch_count == 0) begin
         $display("intel_hex_record_loader: match");
      end else begin
         $display("intel_hex_record_loader: mismatch");
      end
      $finish;
   end

   initial begin : watchdog
      #2000000;
      $display("intel_hex_record_loader: mismatch");
      $finish;
   end

endmodule
`default_nettype wire
